// ===== hw/rtl/itp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types and constants of the timestamp parser.
// ----------------------------------------------------------------------------
package itp_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int unsigned RES_W = 73;

    typedef struct packed {
        logic [7:0] ch;
    } itp_item_t;

    typedef struct packed {
        logic               ok;
        logic [13:0]        year;
        logic [6:0]         month;
        logic [6:0]         day;
        logic [6:0]         hours;
        logic [6:0]         minutes;
        logic signed [29:0] millis;
    } itp_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/itp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// itp_front
// Accepts characters and hands them with a classified digit flag to a queue.
// ----------------------------------------------------------------------------
module itp_front
    import itp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    output logic            q_valid,
    input  wire logic       q_ready,
    output logic [8:0]      q_data
);

    logic [8:0] buf_reg [2];
    logic [1:0] cnt_reg;
    logic       wp_reg;
    logic       rp_reg;
    logic       push;
    logic       pop;
    logic       is_dig;

    assign is_dig   = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_data   = buf_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end else begin
            if (push) begin
                wp_reg <= ~wp_reg;
            end
            if (pop) begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) begin
            buf_reg[wp_reg] <= {is_dig, s_tdata};
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/itp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// itp_back
// Runs the field parser on queued characters and drives the result register.
// ----------------------------------------------------------------------------
module itp_back
    import itp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       q_valid,
    output logic            q_ready,
    input  wire logic [8:0] q_data,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output itp_res_t        m_res
);

    localparam logic [4:0] PH_YEAR = 5'd0, PH_A_YEAR = 5'd1, PH_MONTH = 5'd2,
        PH_A_MONTH = 5'd3, PH_DAY = 5'd4, PH_A_DAY = 5'd5, PH_HOURS = 5'd6,
        PH_A_HOURS = 5'd7, PH_MIN = 5'd8, PH_A_MIN = 5'd9, PH_SEC = 5'd10,
        PH_A_SEC = 5'd11, PH_FRAC = 5'd12, PH_ZONE = 5'd13, PH_OFFH = 5'd14,
        PH_A_OFFH = 5'd15, PH_OFFM = 5'd16;

    logic [4:0]         phase_reg, phase_next;
    logic [2:0]         dcnt_reg, dcnt_next;
    logic [13:0]        acc_reg, acc_next;
    logic [13:0]        year_reg, year_next;
    logic [6:0]         month_reg, month_next, day_reg, day_next;
    logic [6:0]         hours_reg, hours_next, min_reg, min_next;
    logic [6:0]         offh_reg, offh_next;
    logic signed [29:0] millis_reg, millis_next;
    logic               neg_reg, neg_next;
    logic               dec_reg, dec_next;
    logic               ovalid_reg;
    itp_res_t           res_reg;

    logic [7:0]  ch;
    logic        dig;
    logic        fire;
    logic        emit;
    logic        emit_ok;
    logic [4:0]  p;
    logic        digit_path;
    logic [13:0] acc_sum;
    logic [2:0]  cnt_inc;
    logic [2:0]  need;
    logic [31:0] off_ms;
    logic [31:0] sec_ms;
    itp_res_t    res_new;

    assign ch      = q_data[7:0];
    assign dig     = q_data[8];
    assign q_ready = !ovalid_reg || m_tready;
    assign fire    = q_valid && q_ready;
    assign acc_sum = 14'(acc_reg * 14'd10 + 14'(ch - CH_ZERO));
    assign cnt_inc = dcnt_reg + 3'd1;
    assign off_ms  = 32'((32'(offh_reg) * 32'd60 + 32'(acc_sum[6:0])) * 32'd60000);
    assign sec_ms  = 32'(acc_sum) * 32'd1000;

    always_comb begin
        phase_next = phase_reg; dcnt_next = dcnt_reg; acc_next = acc_reg;
        year_next = year_reg; month_next = month_reg; day_next = day_reg;
        hours_next = hours_reg; min_next = min_reg; offh_next = offh_reg;
        millis_next = millis_reg; neg_next = neg_reg; dec_next = dec_reg;
        emit = 1'b0; emit_ok = 1'b0; digit_path = 1'b0; p = phase_reg;
        need = 3'd2;
        if (!dec_reg) begin
            case (phase_reg)
                PH_A_YEAR, PH_A_MONTH: begin
                    if (ch == CH_DASH) begin
                        phase_next = phase_reg + 5'd1;
                    end else begin
                        p = phase_reg + 5'd1; digit_path = 1'b1;
                    end
                end
                PH_A_HOURS, PH_A_MIN, PH_A_OFFH: begin
                    if (ch == CH_COLON) begin
                        phase_next = phase_reg + 5'd1;
                    end else begin
                        p = phase_reg + 5'd1; digit_path = 1'b1;
                    end
                end
                PH_A_DAY, PH_A_SEC, PH_ZONE: begin
                    if (phase_reg == PH_A_DAY && ch == CH_T) begin
                        phase_next = PH_HOURS;
                    end else if (phase_reg == PH_A_SEC && (ch == CH_DOT || ch == CH_COMMA)) begin
                        phase_next = PH_FRAC;
                    end else if (ch == CH_DASH || ch == CH_PLUS) begin
                        neg_next = (ch == CH_DASH); phase_next = PH_OFFH;
                    end else begin
                        emit = 1'b1; emit_ok = (ch == CH_NUL) || (ch == CH_Z);
                    end
                end
                PH_YEAR, PH_MONTH, PH_DAY, PH_HOURS, PH_MIN, PH_SEC, PH_FRAC, PH_OFFH,
                PH_OFFM: begin
                    digit_path = 1'b1;
                end
                default: begin
                    emit = 1'b1;
                end
            endcase
            if (digit_path) begin
                phase_next = p;
                need = (p == PH_YEAR) ? 3'd4 : (p == PH_FRAC) ? 3'd3 : 3'd2;
                if (!dig) begin
                    emit = 1'b1;
                end else if (cnt_inc < need) begin
                    acc_next = acc_sum; dcnt_next = cnt_inc;
                end else begin
                    acc_next = '0; dcnt_next = '0;
                    case (p)
                        PH_YEAR:  begin year_next = acc_sum; phase_next = PH_A_YEAR; end
                        PH_MONTH: begin month_next = acc_sum[6:0]; phase_next = PH_A_MONTH; end
                        PH_DAY:   begin day_next = acc_sum[6:0]; phase_next = PH_A_DAY; end
                        PH_HOURS: begin hours_next = acc_sum[6:0]; phase_next = PH_A_HOURS; end
                        PH_MIN:   begin min_next = acc_sum[6:0]; phase_next = PH_A_MIN; end
                        PH_SEC: begin
                            millis_next = sec_ms[29:0]; phase_next = PH_A_SEC;
                        end
                        PH_FRAC: begin
                            millis_next = millis_reg + 30'(acc_sum); phase_next = PH_ZONE;
                        end
                        PH_OFFH: begin offh_next = acc_sum[6:0]; phase_next = PH_A_OFFH; end
                        default: begin
                            millis_next = neg_reg ? millis_reg + off_ms[29:0]
                                                  : millis_reg - off_ms[29:0];
                            emit = 1'b1; emit_ok = 1'b1;
                        end
                    endcase
                end
            end
            if (emit) begin
                dec_next = 1'b1;
            end
        end
    end

    always_comb begin
        res_new.ok      = emit_ok;
        res_new.year    = emit_ok ? year_next : '0;
        res_new.month   = emit_ok ? month_next : '0;
        res_new.day     = emit_ok ? day_next : '0;
        res_new.hours   = emit_ok ? hours_next : '0;
        res_new.minutes = emit_ok ? min_next : '0;
        res_new.millis  = emit_ok ? millis_next : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_YEAR; dcnt_reg <= '0; acc_reg <= '0; year_reg <= '0;
            month_reg <= '0; day_reg <= '0; hours_reg <= '0; min_reg <= '0;
            offh_reg <= '0; millis_reg <= '0; neg_reg <= 1'b0; dec_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            if (fire && emit) begin
                ovalid_reg <= 1'b1;
            end else if (m_tready) begin
                ovalid_reg <= 1'b0;
            end
            if (fire) begin
                if (ch == CH_NUL) begin
                    phase_reg <= PH_YEAR; dcnt_reg <= '0; acc_reg <= '0; year_reg <= '0;
                    month_reg <= '0; day_reg <= '0; hours_reg <= '0; min_reg <= '0;
                    offh_reg <= '0; millis_reg <= '0; neg_reg <= 1'b0; dec_reg <= 1'b0;
                end else begin
                    phase_reg <= phase_next; dcnt_reg <= dcnt_next; acc_reg <= acc_next;
                    year_reg <= year_next; month_reg <= month_next; day_reg <= day_next;
                    hours_reg <= hours_next; min_reg <= min_next; offh_reg <= offh_next;
                    millis_reg <= millis_next; neg_reg <= neg_next; dec_reg <= dec_next;
                end
            end
        end
        if (fire && emit) begin
            res_reg <= res_new;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_res    = res_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/iso8601_timestamp_parser.sv =====
`default_nettype none
// Path: the character that decides a result is stored in the front queue, then parsed into the result register.
// Throughput: one character per cycle, set by the one-step parser update, while the result output is not stalled.
// A two-entry queue parts the character front from the parser back.
// Reset: synchronous, active low; the parser waits for year digits afterward.
// ----------------------------------------------------------------------------
// iso8601_timestamp_parser
// Streams timestamp characters in and emits one parse result per string.
// ----------------------------------------------------------------------------
module iso8601_timestamp_parser
    import itp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // ch[7:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata    // ok, year, month, day, hours, minutes, millis
);

    logic       q_valid;
    logic       q_ready;
    logic [8:0] q_data;
    itp_res_t   res;

    itp_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    itp_back u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_ready(q_ready),
        .q_data(q_data), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_res(res)
    );

    assign m_tdata = {7'd0, res.millis, res.minutes, res.hours, res.day, res.month,
                      res.year, res.ok};

`ifndef SYNTH
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[72:1] == '0))
        else $error("failed result carries nonzero fields");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

// ===== bench/iso8601_timestamp_parser_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// iso8601_timestamp_parser_tb
// Feeds timestamp strings one character per item, both well formed and broken,
// predicts each parse result in the bench and checks every result field by field.
// ----------------------------------------------------------------------------
module iso8601_timestamp_parser_tb;
    import itp_pkg::*;

    typedef enum int {
        P_YEAR, P_AYEAR, P_MONTH, P_AMONTH, P_DAY, P_ADAY, P_HOURS, P_AHOURS,
        P_MINUTES, P_AMINUTES, P_SECONDS, P_ASECONDS, P_FRAC, P_ZONE, P_OFFH,
        P_AOFFH, P_OFFM
    } parse_phase_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;

    parse_phase_t ph;
    logic [2:0]   dcnt;
    logic [13:0]  acc;
    logic [13:0]  yr;
    logic [6:0]   mo, dy, hr, mi, offh;
    int           ms;
    bit           neg, decided;

    itp_res_t     expected_q[$];
    byte          text_q[$];
    int           errors = 0;
    int           items_sent = 0;
    int           strings_sent = 0;
    int           ok_seen = 0;
    int           fail_seen = 0;
    int           stall_left = 0;
    int           idle_cnt = 0;
    bit           tx_idle = 1'b1;
    bit           rx_idle = 1'b1;

    always #4 aclk = ~aclk;

    iso8601_timestamp_parser u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    function void clear_parser();
        ph = P_YEAR; dcnt = '0; acc = '0; yr = '0; mo = '0; dy = '0; hr = '0;
        mi = '0; offh = '0; ms = 0; neg = 1'b0; decided = 1'b0;
    endfunction

    function void push_result(bit good);
        itp_res_t r;
        r = '0;
        decided = 1'b1;
        if (good) begin
            r.ok = 1'b1; r.year = yr; r.month = mo; r.day = dy;
            r.hours = hr; r.minutes = mi; r.millis = ms[29:0];
        end
        expected_q.push_back(r);
    endfunction

    function void zone_char(logic [7:0] c);
        if (c == CH_DASH || c == CH_PLUS) begin
            neg = (c == CH_DASH);
            ph = P_OFFH;
        end else begin
            push_result(c == CH_NUL || c == CH_Z);
        end
    endfunction

    function void parse_char(logic [7:0] c);
        parse_phase_t p;
        int v, need, off;
        p = ph;
        case (ph)
            P_AYEAR: begin
                if (c == CH_DASH) begin ph = P_MONTH; return; end
                p = P_MONTH;
            end
            P_AMONTH: begin
                if (c == CH_DASH) begin ph = P_DAY; return; end
                p = P_DAY;
            end
            P_AHOURS: begin
                if (c == CH_COLON) begin ph = P_MINUTES; return; end
                p = P_MINUTES;
            end
            P_AMINUTES: begin
                if (c == CH_COLON) begin ph = P_SECONDS; return; end
                p = P_SECONDS;
            end
            P_AOFFH: begin
                if (c == CH_COLON) begin ph = P_OFFM; return; end
                p = P_OFFM;
            end
            P_ADAY: begin
                if (c == CH_T) ph = P_HOURS;
                else zone_char(c);
                return;
            end
            P_ASECONDS: begin
                if (c == CH_DOT || c == CH_COMMA) ph = P_FRAC;
                else zone_char(c);
                return;
            end
            P_ZONE: begin
                zone_char(c);
                return;
            end
            default: ;
        endcase
        ph = p;
        if (c < CH_ZERO || c > CH_NINE) begin
            push_result(1'b0);
            return;
        end
        acc = 14'(int'(acc) * 10 + int'(c - CH_ZERO));
        dcnt = dcnt + 3'd1;
        need = (p == P_YEAR) ? 4 : (p == P_FRAC) ? 3 : 2;
        if (dcnt < need) return;
        v = acc;
        acc = '0;
        dcnt = '0;
        case (p)
            P_YEAR:    begin yr = 14'(v); ph = P_AYEAR; end
            P_MONTH:   begin mo = 7'(v); ph = P_AMONTH; end
            P_DAY:     begin dy = 7'(v); ph = P_ADAY; end
            P_HOURS:   begin hr = 7'(v); ph = P_AHOURS; end
            P_MINUTES: begin mi = 7'(v); ph = P_AMINUTES; end
            P_SECONDS: begin ms = v * 1000; ph = P_ASECONDS; end
            P_FRAC:    begin ms = ms + v; ph = P_ZONE; end
            P_OFFH:    begin offh = 7'(v); ph = P_AOFFH; end
            default: begin
                off = (int'(offh) * 60 + v) * 60000;
                ms = neg ? ms + off : ms - off;
                push_result(1'b1);
            end
        endcase
    endfunction

    function void accept_char(logic [7:0] c);
        if (!decided) parse_char(c);
        if (c == CH_NUL) clear_parser();
    endfunction

    task report_mismatch(string what, longint got, longint want);
        $display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task send_char(logic [7:0] c);
        if (tx_idle && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge aclk); while (!s_tready);
        accept_char(c);
        items_sent++;
    endtask

    function void add_text(string t);
        for (int i = 0; i < t.len(); i++) text_q.push_back(t[i]);
    endfunction

    task send_string(string t);
        add_text(t);
        text_q.push_back(CH_NUL);
        while (text_q.size() > 0) send_char(text_q.pop_front());
        strings_sent++;
    endtask

    function void build_stamp();
        text_q.delete();
        add_text($sformatf("%04d", $urandom_range(0, 9999)));
        if ($urandom_range(0, 1)) text_q.push_back(CH_DASH);
        add_text($sformatf("%02d", $urandom_range(0, 99)));
        if ($urandom_range(0, 1)) text_q.push_back(CH_DASH);
        add_text($sformatf("%02d", $urandom_range(0, 99)));
        if ($urandom_range(0, 3) != 0) begin
            text_q.push_back(CH_T);
            add_text($sformatf("%02d", $urandom_range(0, 99)));
            if ($urandom_range(0, 1)) text_q.push_back(CH_COLON);
            add_text($sformatf("%02d", $urandom_range(0, 99)));
            if ($urandom_range(0, 1)) text_q.push_back(CH_COLON);
            add_text($sformatf("%02d", $urandom_range(0, 99)));
            if ($urandom_range(0, 1)) begin
                text_q.push_back($urandom_range(0, 1) ? CH_DOT : CH_COMMA);
                add_text($sformatf("%03d", $urandom_range(0, 999)));
            end
        end
        case ($urandom_range(0, 3))
            0: ;
            1: text_q.push_back(CH_Z);
            default: begin
                text_q.push_back($urandom_range(0, 1) ? CH_PLUS : CH_DASH);
                add_text($sformatf("%02d", $urandom_range(0, 99)));
                if ($urandom_range(0, 1)) text_q.push_back(CH_COLON);
                add_text($sformatf("%02d", $urandom_range(0, 99)));
            end
        endcase
        if ($urandom_range(0, 5) == 0)
            text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(1, 255));
        if ($urandom_range(0, 6) == 0)
            repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(1, 255)));
        if ($urandom_range(0, 9) == 0)
            text_q = text_q[0:$urandom_range(0, text_q.size() - 1)];
    endfunction

    task wait_drained();
        while (expected_q.size() > 0) @(posedge aclk);
    endtask

    task test_directed();
        send_string("0000-00-00");
        send_string("9999-99-99T99:99:99.999-99:99");
        send_string("99999999T999999,999+9999");
        send_string("2024-02-29T12:34:56.789Z");
        send_string("2024-02-29T12:34:56Zjunk");
        send_string("20240229T0000");
        send_string("");
        send_string("2024x");
        send_string("20");
        send_string("2024-01-01Q");
        send_string("2024-01-01T10:00:00+05:30");
        send_string("\377\200\177\001");
    endtask

    task test_random_stamps();
        while (items_sent < 800) begin
            if (items_sent > 650) begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end
            if ($urandom_range(0, 7) == 0) begin
                text_q.delete();
                repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(1, 255)));
            end else begin
                build_stamp();
            end
            text_q.push_back(CH_NUL);
            while (text_q.size() > 0) send_char(text_q.pop_front());
            strings_sent++;
            if (strings_sent == 20) begin
                s_tvalid <= 1'b0;
                wait_drained();
                @(posedge aclk);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (rx_idle && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 7);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        itp_res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.ok      = m_tdata[0];
            got.year    = m_tdata[14:1];
            got.month   = m_tdata[21:15];
            got.day     = m_tdata[28:22];
            got.hours   = m_tdata[35:29];
            got.minutes = m_tdata[42:36];
            got.millis  = m_tdata[72:43];
            if (expected_q.size() == 0) begin
                $display("unexpected result at %0t", $realtime);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (got.ok) ok_seen++; else fail_seen++;
                if (got.ok != want.ok) report_mismatch("ok", got.ok, want.ok);
                if (got.year != want.year) report_mismatch("year", got.year, want.year);
                if (got.month != want.month) report_mismatch("month", got.month, want.month);
                if (got.day != want.day) report_mismatch("day", got.day, want.day);
                if (got.hours != want.hours) report_mismatch("hours", got.hours, want.hours);
                if (got.minutes != want.minutes)
                    report_mismatch("minutes", got.minutes, want.minutes);
                if (got.millis != want.millis)
                    report_mismatch("millis", got.millis, want.millis);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= 5000) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    initial begin
        clear_parser();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_stamps();
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge aclk);
        $display("Sent %0d characters in %0d strings.", items_sent, strings_sent);
        $display("Checked %0d good and %0d failed parses.", ok_seen, fail_seen);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/itp_pkg.sv
hw/rtl/itp_front.sv
hw/rtl/itp_back.sv
hw/rtl/iso8601_timestamp_parser.sv
bench/iso8601_timestamp_parser_tb.sv
